// ===== rtl/etrb_pkg.sv =====
// Shared definitions for the event trace ring buffer: action codes,
// register indexes, field widths and the stored entry layout.
// No dependencies.
package etrb_pkg;

  // Field widths fixed by the interface.
  localparam int DATA_W    = 32;
  localparam int ACT_W     = 2;
  localparam int POS_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Default ring depth, legal range 1 to 64.
  localparam int DEPTH_DEF = 64;

  // Action codes carried by each input transfer.
  localparam logic [ACT_W-1:0] ACT_START = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STOP  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EVENT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DUMP  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_IF_FULL  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_EVENT_ID = 1'd1;

  // One ring entry as it sits in memory.
  typedef struct packed {
    logic [DATA_W-1:0] stamp;
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] pa;
    logic [DATA_W-1:0] pb;
    logic [DATA_W-1:0] pc;
    logic [DATA_W-1:0] pd;
  } entry_t;

endpackage

// ===== rtl/etrb_ring_mem.sv =====
// Entry storage for the event trace ring buffer: one write port and one
// read port with registered read data. Depends on etrb_pkg.
module etrb_ring_mem #(
  parameter int DEPTH = etrb_pkg::DEPTH_DEF,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  etrb_pkg::entry_t    wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output etrb_pkg::entry_t    rd_data
);
  import etrb_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/event_trace_ring_buffer_top.sv =====
// Top level of the event trace ring buffer: capture control, dump sequencer
// and result registers. Depends on etrb_pkg and etrb_ring_mem.
//
// Start, stop and event commands may follow one another in consecutive
// cycles; busy stays low for them. A dump command holding n stored entries
// raises busy while it makes n reads, one per entry, of the single memory
// read port, and each entry appears on the out_ ports for one cycle, in the
// cycle after its read, marked by out_valid and shown oldest first with
// out_last on the final one. A dump with nothing stored produces no result
// and busy stays low. The receiver cannot stall: every strobed result must be
// taken in the cycle it is shown. Stored entries survive a dump and are shown
// again by a later one. Configuration writes take effect at once, so they
// belong in idle periods with no command or dump in flight.
module event_trace_ring_buffer_top #(
  parameter int DEPTH = etrb_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Command channel.
  input  logic                            start,
  output logic                            busy,
  input  logic [etrb_pkg::ACT_W-1:0]      in_action,
  input  logic [etrb_pkg::DATA_W-1:0]     in_time_now,
  input  logic [etrb_pkg::DATA_W-1:0]     in_event_id,
  input  logic [etrb_pkg::DATA_W-1:0]     in_param_a,
  input  logic [etrb_pkg::DATA_W-1:0]     in_param_b,
  input  logic [etrb_pkg::DATA_W-1:0]     in_param_c,
  input  logic [etrb_pkg::DATA_W-1:0]     in_param_d,
  // Result channel.
  output logic                            out_valid,
  output logic [etrb_pkg::POS_W-1:0]      out_position,
  output logic [etrb_pkg::DATA_W-1:0]     out_elapsed_ticks,
  output logic [etrb_pkg::DATA_W-1:0]     out_entry_id,
  output logic [etrb_pkg::DATA_W-1:0]     out_entry_a,
  output logic [etrb_pkg::DATA_W-1:0]     out_entry_b,
  output logic [etrb_pkg::DATA_W-1:0]     out_entry_c,
  output logic [etrb_pkg::DATA_W-1:0]     out_entry_d,
  output logic                            out_last,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [etrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [etrb_pkg::DATA_W-1:0]     cfg_wdata
);
  import etrb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  // Sequencer state codes.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  // Configuration registers.
  logic              stop_if_full_r;
  logic [DATA_W-1:0] stop_event_id_r;

  // Capture state.
  logic              armed_r, armed_nxt;
  logic [DATA_W-1:0] start_time_r, start_time_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;

  // Dump sequencer.
  logic              state_r, state_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     dump_n_r, dump_n_nxt;

  // Result side registers.
  logic              out_valid_r;
  logic [CW-1:0]     out_pos_r;
  logic              out_last_r;

  // Memory ports.
  logic              wr_en;
  entry_t            wr_data;
  logic              rd_en;
  entry_t            rd_data;

  logic              accept;
  logic              rec_req;
  logic              is_event;

  assign accept   = start && !busy;
  assign busy     = (state_r == ST_DUMP);
  assign is_event = (in_action == ACT_EVENT);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_if_full_r  <= 1'b0;
      stop_event_id_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STOP_IF_FULL:  stop_if_full_r  <= cfg_wdata[0];
        CFG_STOP_EVENT_ID: stop_event_id_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Record request: events, stops, and the implied stop of a dump while armed.
  assign rec_req = accept && armed_r &&
                   (is_event || (in_action == ACT_STOP) || (in_action == ACT_DUMP));

  // Entry being written; stop records carry zero parameters.
  always_comb begin
    wr_data.stamp = in_time_now - start_time_r;
    wr_data.id    = is_event ? in_event_id : stop_event_id_r;
    wr_data.pa    = is_event ? in_param_a : '0;
    wr_data.pb    = is_event ? in_param_b : '0;
    wr_data.pc    = is_event ? in_param_c : '0;
    wr_data.pd    = is_event ? in_param_d : '0;
  end

  // Capture control and dump setup.
  always_comb begin
    armed_nxt      = armed_r;
    start_time_nxt = start_time_r;
    fill_nxt       = fill_r;
    slot_nxt       = slot_r;
    wr_en          = 1'b0;
    state_nxt      = state_r;
    rd_addr_nxt    = rd_addr_r;
    pos_nxt        = pos_r;
    dump_n_nxt     = dump_n_r;

    // Store into the ring, or disarm when full and overwrite is off.
    if (rec_req) begin
      if (fill_r < FULL_CNT) begin
        fill_nxt = fill_r + CW'(1);
        wr_en    = 1'b1;
      end else if (stop_if_full_r) begin
        armed_nxt = 1'b0;
      end else begin
        wr_en = 1'b1;
      end
      if (wr_en) begin
        slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + AW'(1);
      end
    end

    if (accept) begin
      unique case (in_action)
        ACT_START: begin
          armed_nxt      = 1'b1;
          start_time_nxt = in_time_now;
        end
        ACT_STOP: begin
          armed_nxt = 1'b0;
        end
        ACT_EVENT: ;
        ACT_DUMP: begin
          armed_nxt = 1'b0;
          if (fill_nxt != '0) begin
            state_nxt   = ST_DUMP;
            dump_n_nxt  = fill_nxt;
            pos_nxt     = CW'(1);
            rd_addr_nxt = (fill_nxt == FULL_CNT) ? slot_nxt : '0;
          end
        end
        default: ;
      endcase
    end

    // One read per cycle while dumping.
    if (state_r == ST_DUMP) begin
      rd_addr_nxt = (rd_addr_r == LAST_SLOT) ? '0 : rd_addr_r + AW'(1);
      pos_nxt     = pos_r + CW'(1);
      if (pos_r == dump_n_r) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  assign rd_en = (state_r == ST_DUMP);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      start_time_r <= '0;
      fill_r       <= '0;
      slot_r       <= '0;
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
    end else begin
      armed_r      <= armed_nxt;
      start_time_r <= start_time_nxt;
      fill_r       <= fill_nxt;
      slot_r       <= slot_nxt;
      state_r      <= state_nxt;
      out_valid_r  <= rd_en;
    end
  end

  // Sequencer payload registers, aligned with the memory read latency.
  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    pos_r      <= pos_nxt;
    dump_n_r   <= dump_n_nxt;
    out_pos_r  <= pos_r;
    out_last_r <= (pos_r == dump_n_r);
  end

  etrb_ring_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ring_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  // Result ports.
  assign out_valid         = out_valid_r;
  assign out_position      = POS_W'(out_pos_r);
  assign out_last          = out_last_r;
  assign out_elapsed_ticks = rd_data.stamp;
  assign out_entry_id      = rd_data.id;
  assign out_entry_a       = rd_data.pa;
  assign out_entry_b       = rd_data.pb;
  assign out_entry_c       = rd_data.pc;
  assign out_entry_d       = rd_data.pd;

endmodule

// ===== verif/tb.sv =====
// Testbench for event_trace_ring_buffer_top: drives start, stop, event and dump
// commands, keeps its own copy of the trace ring and checks every dumped entry.
// Depends on etrb_pkg and the RTL of event_trace_ring_buffer_top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etrb_pkg::*;

  localparam int RING_DEPTH   = DEPTH_DEF;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 100;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_CMDS   = 26;

  // One dumped trace entry as it is expected on the result ports.
  typedef struct {
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] elapsed;
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] pa;
    logic [DATA_W-1:0] pb;
    logic [DATA_W-1:0] pc;
    logic [DATA_W-1:0] pd;
    logic              last;
  } dump_rec_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [ACT_W-1:0]   in_action;
  logic [DATA_W-1:0]  in_time_now;
  logic [DATA_W-1:0]  in_event_id;
  logic [DATA_W-1:0]  in_param_a;
  logic [DATA_W-1:0]  in_param_b;
  logic [DATA_W-1:0]  in_param_c;
  logic [DATA_W-1:0]  in_param_d;
  logic               out_valid;
  logic [POS_W-1:0]   out_position;
  logic [DATA_W-1:0]  out_elapsed_ticks;
  logic [DATA_W-1:0]  out_entry_id;
  logic [DATA_W-1:0]  out_entry_a;
  logic [DATA_W-1:0]  out_entry_b;
  logic [DATA_W-1:0]  out_entry_c;
  logic [DATA_W-1:0]  out_entry_d;
  logic               out_last;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]  cfg_wdata;

  event_trace_ring_buffer_top #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_time_now(in_time_now),
    .in_event_id(in_event_id),
    .in_param_a(in_param_a),
    .in_param_b(in_param_b),
    .in_param_c(in_param_c),
    .in_param_d(in_param_d),
    .out_valid(out_valid),
    .out_position(out_position),
    .out_elapsed_ticks(out_elapsed_ticks),
    .out_entry_id(out_entry_id),
    .out_entry_a(out_entry_a),
    .out_entry_b(out_entry_b),
    .out_entry_c(out_entry_c),
    .out_entry_d(out_entry_d),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Free-running clock, 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Trace ring as the testbench expects it to be.
  logic [DATA_W-1:0] ring_stamp [RING_DEPTH];
  logic [DATA_W-1:0] ring_id    [RING_DEPTH];
  logic [DATA_W-1:0] ring_par   [RING_DEPTH][4];
  logic              cap_armed = 1'b0;
  logic [DATA_W-1:0] t_base = '0;
  int                held = 0;
  int                wr_ptr = 0;
  logic              mir_stop_full = 1'b0;
  logic [DATA_W-1:0] mir_stop_id = '0;

  dump_rec_t         dump_fifo[$];
  int                errors = 0;
  int                cmds_sent = 0;
  int                quiet_run = 0;
  int                idle_cycles = 0;
  logic [DATA_W-1:0] tick = '0;

  // Store one entry while capture is armed; a full ring either wraps or,
  // with stop-if-full set, disarms and drops the entry.
  function automatic void log_entry(input logic [DATA_W-1:0] now, id, a, b, c, d);
    if (!cap_armed)
      return;
    if (held < RING_DEPTH) begin
      held++;
    end else if (mir_stop_full) begin
      cap_armed = 1'b0;
      return;
    end
    ring_stamp[wr_ptr] = now - t_base;
    ring_id[wr_ptr]    = id;
    ring_par[wr_ptr][0] = a;
    ring_par[wr_ptr][1] = b;
    ring_par[wr_ptr][2] = c;
    ring_par[wr_ptr][3] = d;
    wr_ptr = (wr_ptr == RING_DEPTH - 1) ? 0 : wr_ptr + 1;
  endfunction

  // A stop writes the stop record with zero parameters, then disarms.
  function automatic void halt_capture(input logic [DATA_W-1:0] now);
    log_entry(now, mir_stop_id, '0, '0, '0, '0);
    cap_armed = 1'b0;
  endfunction

  // Update the expected state for one accepted command and queue the
  // entries that a dump shows, oldest first.
  function automatic void apply_cmd(input logic [ACT_W-1:0] act,
                                    input logic [DATA_W-1:0] now, id, a, b, c, d);
    int span;
    int rd;
    dump_rec_t rec;
    case (act)
      ACT_START: begin
        t_base = now;
        cap_armed = 1'b1;
      end
      ACT_STOP: halt_capture(now);
      ACT_EVENT: log_entry(now, id, a, b, c, d);
      default: begin
        if (cap_armed)
          halt_capture(now);
        span = held;
        rd = (span == RING_DEPTH) ? wr_ptr : 0;
        for (int i = 0; i < span; i++) begin
          rec.position = POS_W'(i + 1);
          rec.elapsed  = ring_stamp[rd];
          rec.id       = ring_id[rd];
          rec.pa       = ring_par[rd][0];
          rec.pb       = ring_par[rd][1];
          rec.pc       = ring_par[rd][2];
          rec.pd       = ring_par[rd][3];
          rec.last     = (i == span - 1);
          dump_fifo.push_back(rec);
          rd = (rd == RING_DEPTH - 1) ? 0 : rd + 1;
        end
      end
    endcase
  endfunction

  // Mostly back-to-back commands, some short gaps, a few long ones, and now
  // and then a stretch with no gaps at all.
  function automatic int pick_gap();
    int r;
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_run = $urandom_range(20, 40);
      return 0;
    end
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one command and hold it until the block takes the transfer.
  task automatic send_cmd(input logic [ACT_W-1:0] act,
                          input logic [DATA_W-1:0] now, id, a, b, c, d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      in_action = ACT_W'($urandom());
      in_time_now = $urandom();
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start       = 1'b1;
    in_action   = act;
    in_time_now = now;
    in_event_id = id;
    in_param_a  = a;
    in_param_b  = b;
    in_param_c  = c;
    in_param_d  = d;
    do @(posedge clk); while (busy);
    apply_cmd(act, now, id, a, b, c, d);
    cmds_sent++;
  endtask

  // Start, stop and dump with random values on the fields they ignore.
  task automatic send_ctl(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] now);
    send_cmd(act, now, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic send_event(input logic [DATA_W-1:0] now);
    send_cmd(ACT_EVENT, now, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic go_quiet();
    @(negedge clk);
    start = 1'b0;
  endtask

  // Wait until every expected entry has arrived and the block has settled.
  task automatic wait_idle();
    go_quiet();
    while (dump_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = $urandom();
    if (idx == CFG_STOP_IF_FULL)
      mir_stop_full = val[0];
    else
      mir_stop_id = val;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want_v, got_v);
    if (got_v !== want_v) begin
      errors++;
      // Further mismatches are counted but not printed.
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
    end
  endtask

  // Compare each result transfer with the oldest expected entry.
  always @(posedge clk) begin : chk_results
    dump_rec_t want;
    if (rst_n && out_valid) begin
      if (dump_fifo.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: unexpected result: expected none, actual position %0d",
                   $time, out_position);
      end else begin
        want = dump_fifo.pop_front();
        check_field("position", DATA_W'(want.position), DATA_W'(out_position));
        check_field("elapsed_ticks", want.elapsed, out_elapsed_ticks);
        check_field("entry_id", want.id, out_entry_id);
        check_field("entry_a", want.pa, out_entry_a);
        check_field("entry_b", want.pb, out_entry_b);
        check_field("entry_c", want.pc, out_entry_c);
        check_field("entry_d", want.pd, out_entry_d);
        check_field("last", DATA_W'(want.last), DATA_W'(out_last));
      end
    end
  end

  // End the run when neither side has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[event_trace_ring_buffer_top] ERROR");
        $finish;
      end
    end
  end

  // Empty ring: dumps show nothing, stop and event while disarmed are ignored.
  task automatic test_empty_ring();
    write_reg(CFG_STOP_IF_FULL, 32'h0);
    write_reg(CFG_STOP_EVENT_ID, 32'hFFFF_FFFF);
    send_ctl(ACT_DUMP, 32'h0);
    send_ctl(ACT_STOP, 32'h10);
    send_cmd(ACT_EVENT, 32'h20, 32'hFFFF_FFFF, '1, '1, '1, '1);
    send_ctl(ACT_DUMP, 32'hFFFF_FFFF);
  endtask

  // Time base wrap, field extremes, restart while armed, stop record,
  // repeated dump and a dump that stops capture itself.
  task automatic test_capture_basics();
    send_ctl(ACT_START, 32'hFFFF_FFF0);
    send_cmd(ACT_EVENT, 32'h0000_000F, 32'h0, '1, '1, '1, '1);
    send_cmd(ACT_EVENT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, '0, '0, '0, '0);
    send_cmd(ACT_EVENT, 32'hFFFF_FFEF, 32'hA5A5_5A5A,
             32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
    send_ctl(ACT_START, 32'h0000_0100);
    send_event(32'h0000_0180);
    send_ctl(ACT_STOP, 32'h0000_0200);
    send_event(32'h0000_0300);
    send_ctl(ACT_STOP, 32'h0000_0400);
    send_ctl(ACT_DUMP, 32'h0000_0500);
    send_ctl(ACT_DUMP, 32'h0000_0600);
    send_ctl(ACT_START, 32'h0);
    send_event(32'hFFFF_FFFF);
    send_ctl(ACT_DUMP, 32'h0000_0007);
  endtask

  // Stop-if-full: fill the ring, then an event and a stop that find it full
  // are dropped and disarm capture.
  task automatic test_stop_if_full();
    wait_idle();
    write_reg(CFG_STOP_IF_FULL, 32'h1);
    write_reg(CFG_STOP_EVENT_ID, 32'h0);
    tick = 32'h1000;
    send_ctl(ACT_START, tick);
    while (held < RING_DEPTH) begin
      tick += $urandom_range(0, 40);
      send_event(tick);
    end
    repeat (3) begin
      tick += $urandom_range(1, 40);
      send_event(tick);
    end
    send_ctl(ACT_DUMP, tick);
    send_ctl(ACT_START, tick + 32'd5);
    send_ctl(ACT_STOP, tick + 32'd9);
    send_ctl(ACT_DUMP, tick + 32'd12);
  endtask

  // Overwrite: more events than the ring holds, across a time wrap.
  task automatic test_ring_wrap();
    wait_idle();
    write_reg(CFG_STOP_IF_FULL, 32'hFFFF_FFFE);
    write_reg(CFG_STOP_EVENT_ID, 32'h1234_5678);
    tick = 32'hFFFF_FFC0;
    send_ctl(ACT_START, tick);
    repeat (RING_DEPTH + 6) begin
      tick += 32'd1;
      send_event(tick);
    end
    send_ctl(ACT_STOP, tick + 32'd3);
    send_ctl(ACT_DUMP, tick + 32'd4);
    send_ctl(ACT_DUMP, tick + 32'd5);
  endtask

  // Random traffic in phases with a new register setting each: mostly
  // start, events, optional stop and dump, with loose commands mixed in.
  task automatic test_random_traffic();
    int target;
    int r;
    int n_ev;
    logic [DATA_W-1:0] sid;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      write_reg(CFG_STOP_IF_FULL, {(DATA_W-1)'($urandom()), (ph % 3 == 2)});
      r = $urandom_range(0, 3);
      sid = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
      write_reg(CFG_STOP_EVENT_ID, sid);
      target = cmds_sent + PHASE_CMDS;
      while (cmds_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          if ($urandom_range(0, 9) == 0)
            tick = $urandom();
          send_ctl(ACT_START, tick);
          n_ev = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 8);
          repeat (n_ev) begin
            tick += $urandom_range(0, 40);
            send_event(tick);
          end
          if ($urandom_range(0, 1) == 1) begin
            tick += $urandom_range(0, 40);
            send_ctl(ACT_STOP, tick);
          end
          if ($urandom_range(0, 3) != 0) begin
            tick += $urandom_range(0, 40);
            send_ctl(ACT_DUMP, tick);
          end
        end else begin
          send_ctl(ACT_W'($urandom_range(0, 3)), $urandom());
        end
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_action   = ACT_START;
    in_time_now = '0;
    in_event_id = '0;
    in_param_a  = '0;
    in_param_b  = '0;
    in_param_c  = '0;
    in_param_d  = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_STOP_IF_FULL;
    cfg_wdata   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_ring();
    test_capture_basics();
    test_stop_if_full();
    test_ring_wrap();
    test_random_traffic();

    // Drain the last dump and give stray results time to show.
    go_quiet();
    while (dump_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[event_trace_ring_buffer_top] OK");
    else
      $display("[event_trace_ring_buffer_top] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/etrb_pkg.sv
rtl/etrb_ring_mem.sv
rtl/event_trace_ring_buffer_top.sv
verif/tb.sv
